[rtl/tag_presence_table_with_aging_top_macros.svh]
// Assertion macros for the tag presence table.
`ifndef TAG_PRESENCE_TABLE_WITH_AGING_TOP_MACROS_SVH
`define TAG_PRESENCE_TABLE_WITH_AGING_TOP_MACROS_SVH
// Checks that a condition implies a consequence in the same cycle.
`define TPT_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define TPT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

[rtl/tpt_pkg.sv]
// Package with types and constants of the tag presence table.
`timescale 1ns / 1ps
package tpt_pkg;
	localparam int MaxEntries = 16;
	localparam int KeyBytes = 16;
	localparam logic [15:0] ResetTimeout = 16'd3000;

	typedef enum logic [1:0] {
		OP_CHUNK = 2'd0,
		OP_TICK = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_REFRESHED = 3'd0,
		ST_ADDED = 3'd1,
		ST_FULL = 3'd2,
		ST_EMPTY = 3'd3,
		ST_TICK = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_SWEEP,
		S_EVAL,
		S_DONE
	} state_t;
endpackage

[rtl/tag_presence_table_with_aging_top.sv]
// Top level of the tag presence table with aging.
// Results: a clear or a zero-length last chunk answers in the cycle after acceptance, a
// last chunk answers after a search of the entries in slot order that ends at a hit or a
// miss, and a tick after a sweep over all entries; other chunks and code 3 give no result.
// Flow: only a search or a sweep holds busy, and the next item is then taken in the
// cycle after its result; results are strobed.
// Reset clears the time, the entry count, the chunk index and sets the timeout to 3000.
`timescale 1ns / 1ps
`include "tag_presence_table_with_aging_top_macros.svh"
module tag_presence_table_with_aging_top #(
	parameter int MAX_ENTRIES = tpt_pkg::MaxEntries,
	parameter int KEY_BYTES = tpt_pkg::KeyBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [63:0] key_chunk,
	input  logic        chunk_last,
	input  logic [4:0]  key_length_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [2:0]  status,
	output logic [3:0]  entry_slot,
	output logic [4:0]  entries_in_use,
	output logic [4:0]  expired_count
);
	localparam int KW = (KEY_BYTES + 7) / 8;
	localparam int KWB = (KW > 1) ? $clog2(KW) : 1;
	localparam int KB = KW * 64;
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = $clog2(KEY_BYTES + 1);
	localparam int EW = KB + LW + 32;

	tpt_pkg::state_t state_q, state_d;
	logic [15:0] timeout_q;
	logic [31:0] time_q;
	logic [CW-1:0] count_q, rd_q, wr_q, exp_q;
	logic [KB-1:0] inkey_q;
	logic [KWB:0] cidx_q;
	logic [KB-1:0] key_q;
	logic [LW-1:0] len_q;

	logic [EW-1:0] mem [MAX_ENTRIES];
	logic [EW-1:0] rdata_s1;
	logic [IW-1:0] raddr;
	logic re, we;
	logic [IW-1:0] waddr;
	logic [EW-1:0] wdata;

	logic accept;
	logic [KB-1:0] inkey_n, mask;
	logic [LW-1:0] len_sat;
	logic [KB-1:0] r_key;
	logic [LW-1:0] r_len;
	logic [31:0] r_time;
	logic match, expired;

	assign busy = (state_q != tpt_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_comb begin
		inkey_n = inkey_q;
		if (cidx_q < (KWB + 1)'(KW))
			inkey_n[KB-1-64*cidx_q[KWB-1:0] -: 64] = key_chunk;
		len_sat = (key_length_bytes > 5'(KEY_BYTES)) ? LW'(KEY_BYTES) : LW'(key_length_bytes);
		for (int b = 0; b < KW * 8; b++)
			mask[KB-1-8*b -: 8] = (b < int'(len_sat)) ? 8'hff : 8'h00;
	end

	assign r_key = rdata_s1[EW-1 -: KB];
	assign r_len = rdata_s1[32 +: LW];
	assign r_time = rdata_s1[31:0];
	assign match = (r_len == len_q) && (r_key == key_q);
	assign expired = (time_q - r_time) > {16'd0, timeout_q};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_s1 <= mem[raddr];
	end

	always_comb begin
		state_d = state_q;
		re = 1'b0;
		raddr = rd_q[IW-1:0];
		we = 1'b0;
		waddr = wr_q[IW-1:0];
		wdata = rdata_s1;
		case (state_q)
			tpt_pkg::S_IDLE: begin
				if (accept && operation == tpt_pkg::OP_CHUNK && chunk_last
					&& len_sat != '0)
					state_d = tpt_pkg::S_SRCH;
				else if (accept && operation == tpt_pkg::OP_TICK)
					state_d = tpt_pkg::S_SWEEP;
			end
			tpt_pkg::S_SRCH: begin
				if (rd_q < count_q) begin
					re = 1'b1;
					state_d = tpt_pkg::S_CMP;
				end else begin
					if (count_q < CW'(MAX_ENTRIES)) begin
						we = 1'b1;
						waddr = count_q[IW-1:0];
						wdata = {key_q, len_q, time_q};
					end
					state_d = tpt_pkg::S_DONE;
				end
			end
			tpt_pkg::S_CMP: begin
				if (match) begin
					we = 1'b1;
					waddr = rd_q[IW-1:0];
					wdata = {key_q, len_q, time_q};
					state_d = tpt_pkg::S_DONE;
				end else
					state_d = tpt_pkg::S_SRCH;
			end
			tpt_pkg::S_SWEEP: begin
				if (rd_q < count_q) begin
					re = 1'b1;
					state_d = tpt_pkg::S_EVAL;
				end else
					state_d = tpt_pkg::S_DONE;
			end
			tpt_pkg::S_EVAL: begin
				we = !expired;
				state_d = tpt_pkg::S_SWEEP;
			end
			tpt_pkg::S_DONE: state_d = tpt_pkg::S_IDLE;
			default: state_d = tpt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpt_pkg::S_IDLE;
			timeout_q <= tpt_pkg::ResetTimeout;
			time_q <= '0;
			count_q <= '0;
			cidx_q <= '0;
			inkey_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			exp_q <= '0;
			result_valid <= 1'b0;
			status <= '0;
			entry_slot <= '0;
			entries_in_use <= '0;
			expired_count <= '0;
		end else begin
			state_q <= state_d;
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready)
				timeout_q <= cfg_data;
			case (state_q)
				tpt_pkg::S_IDLE: begin
					rd_q <= '0;
					wr_q <= '0;
					exp_q <= '0;
					if (accept) begin
						case (operation)
							tpt_pkg::OP_CHUNK: begin
								if (chunk_last) begin
									key_q <= inkey_n & mask;
									len_q <= len_sat;
									inkey_q <= '0;
									cidx_q <= '0;
									if (len_sat == '0) begin
										result_valid <= 1'b1;
										status <= tpt_pkg::ST_EMPTY;
										entry_slot <= '0;
										entries_in_use <= 5'(count_q);
										expired_count <= '0;
									end
								end else begin
									inkey_q <= inkey_n;
									if (cidx_q < (KWB + 1)'(KW))
										cidx_q <= cidx_q + 1'b1;
								end
							end
							tpt_pkg::OP_TICK: time_q <= time_q + 32'd1;
							tpt_pkg::OP_CLEAR: begin
								count_q <= '0;
								inkey_q <= '0;
								cidx_q <= '0;
								result_valid <= 1'b1;
								status <= tpt_pkg::ST_CLEARED;
								entry_slot <= '0;
								entries_in_use <= '0;
								expired_count <= '0;
							end
							default: ;
						endcase
					end
				end
				tpt_pkg::S_SRCH: begin
					if (!(rd_q < count_q)) begin
						result_valid <= 1'b1;
						expired_count <= '0;
						if (count_q < CW'(MAX_ENTRIES)) begin
							status <= tpt_pkg::ST_ADDED;
							entry_slot <= 4'(count_q);
							entries_in_use <= 5'(count_q + 1'b1);
							count_q <= count_q + 1'b1;
						end else begin
							status <= tpt_pkg::ST_FULL;
							entry_slot <= '0;
							entries_in_use <= 5'(count_q);
						end
					end
				end
				tpt_pkg::S_CMP: begin
					if (match) begin
						result_valid <= 1'b1;
						status <= tpt_pkg::ST_REFRESHED;
						entry_slot <= 4'(rd_q);
						entries_in_use <= 5'(count_q);
						expired_count <= '0;
					end else
						rd_q <= rd_q + 1'b1;
				end
				tpt_pkg::S_SWEEP: begin
					if (!(rd_q < count_q)) begin
						count_q <= wr_q;
						result_valid <= 1'b1;
						status <= tpt_pkg::ST_TICK;
						entry_slot <= '0;
						entries_in_use <= 5'(wr_q);
						expired_count <= 5'(exp_q);
					end
				end
				tpt_pkg::S_EVAL: begin
					rd_q <= rd_q + 1'b1;
					if (expired)
						exp_q <= exp_q + 1'b1;
					else
						wr_q <= wr_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	`TPT_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_ENTRIES), "entry count above capacity")
	`TPT_ASSERT_IMPL(a_write_order, clk, arst_n, state_q == tpt_pkg::S_EVAL, wr_q <= rd_q, "compaction write passed read")
	`TPT_ASSERT_NEXT(a_done_result, clk, arst_n, state_q == tpt_pkg::S_DONE, !busy, "done state did not return to idle")
	`TPT_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, busy, !accept, "item accepted while busy")
endmodule
